[rtl/assert_macros.svh]
// Assertion macros included by the generator top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
		else $error(msg);

// Antecedent in a cycle implies consequent in the same cycle.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

[rtl/mtp_pkg.sv]
// Package: constants and the tempering function of the Mersenne Twister generator.
package mtp_pkg;

	// State vector geometry
	localparam int unsigned STATE_DEPTH   = 624;
	localparam int unsigned MIDDLE_OFFSET = 397;
	localparam int unsigned ADDR_W        = $clog2(STATE_DEPTH);

	// Output queue depth: two in flight plus one waiting word
	localparam int unsigned OUTQ_DEPTH = 3;
	localparam int unsigned OUTQ_PTR_W = $clog2(OUTQ_DEPTH);
	localparam int unsigned OUTQ_CNT_W = $clog2(OUTQ_DEPTH + 1);

	// Generator constants
	localparam logic [31:0] TWIST_MATRIX = 32'h9908_b0df;
	localparam logic [31:0] INIT_MULT    = 32'd1812433253;
	localparam logic [31:0] DEFAULT_SEED = 32'd5489;
	localparam logic [31:0] TEMPER_B     = 32'h9d2c_5680;
	localparam logic [31:0] TEMPER_C     = 32'hefc6_0000;

	// Output tempering: shifts and masks only
	function automatic logic [31:0] temper(input logic [31:0] w);
		logic [31:0] y;
		y = w ^ (w >> 11);
		y = y ^ ((y << 7) & TEMPER_B);
		y = y ^ ((y << 15) & TEMPER_C);
		y = y ^ (y >> 18);
		return y;
	endfunction

endpackage

[rtl/mersenne_twister_prng.sv]
// Top level: MT19937 generator with the state vector held in one synchronous RAM.
// One tempered word is returned per accepted request with draw set, at one word
// per cycle sustained while no refill runs and the output queue has room; a result
// passes through the stage 1 registers and the output queue before it is offered.
// Each draw twists a single state word: the RAM has two read ports (next word and
// middle word) and one write port, and the current word is kept in a register from
// the previous draw's read, so draws never stall on the RAM. After reset, and after
// every write of the seed register, the 624 state words are refilled one per cycle
// by the seeding recurrence (one 32-bit multiply per cycle), so in_ready stays low
// until the refill is done. A request with draw clear is taken and gives no result.
`include "assert_macros.svh"

module mersenne_twister_prng (
	input  logic        clk,
	input  logic        arst_n,
	// seed register
	input  logic        cfg_we,
	input  logic [31:0] cfg_wdata,
	// request channel
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        draw,
	// result channel
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] word32,
	output logic [30:0] word31
);

	typedef logic [mtp_pkg::ADDR_W-1:0]     addr_t;
	typedef logic [mtp_pkg::OUTQ_PTR_W-1:0] qptr_t;
	typedef logic [mtp_pkg::OUTQ_CNT_W-1:0] qcnt_t;

	localparam addr_t LAST_ADDR = addr_t'(mtp_pkg::STATE_DEPTH - 1);
	localparam addr_t MID_OFS   = addr_t'(mtp_pkg::MIDDLE_OFFSET);
	localparam logic [mtp_pkg::ADDR_W:0] DEPTH_EXT = (mtp_pkg::ADDR_W+1)'(mtp_pkg::STATE_DEPTH);
	localparam qptr_t Q_LAST    = qptr_t'(mtp_pkg::OUTQ_DEPTH - 1);
	localparam logic [mtp_pkg::OUTQ_CNT_W:0] Q_FULL = (mtp_pkg::OUTQ_CNT_W+1)'(mtp_pkg::OUTQ_DEPTH);

	// State RAM
	logic [31:0] state_mem [mtp_pkg::STATE_DEPTH];

	// Control registers
	logic [31:0] seed_q;
	logic        fill_q;
	addr_t       fill_idx_q;
	addr_t       index_q;
	logic        valid_s1;
	addr_t       widx_s1;

	// Datapath registers
	logic [31:0] prev_q;
	logic [31:0] cur_q;
	logic [31:0] rd_nxt_s1;
	logic [31:0] rd_mid_s1;

	// Output queue
	logic [31:0] outq_q [mtp_pkg::OUTQ_DEPTH];
	qptr_t       wr_ptr_q;
	qptr_t       rd_ptr_q;
	qcnt_t       cnt_q;

	logic                    accept;
	logic                    take;
	logic                    pop;
	addr_t                   nxt_addr;
	addr_t                   mid_addr;
	logic [mtp_pkg::ADDR_W:0] mid_sum;
	logic [mtp_pkg::OUTQ_CNT_W:0] occupancy;
	logic [31:0]             fill_mix;
	logic [31:0]             fill_prod;
	logic [31:0]             fill_word;
	logic [31:0]             y_word;
	logic [31:0]             twist_w;
	logic                    mem_we;
	addr_t                   mem_waddr;
	logic [31:0]             mem_wdata;

	// Handshake
	assign occupancy = {1'b0, cnt_q} + {{mtp_pkg::OUTQ_CNT_W{1'b0}}, valid_s1};
	assign in_ready  = !fill_q && (occupancy < Q_FULL);
	assign accept    = in_valid && in_ready;
	assign take      = accept && draw;
	assign pop       = out_valid && out_ready;

	// Neighbour addresses, modulo the state depth
	assign nxt_addr = (index_q == LAST_ADDR) ? '0 : index_q + addr_t'(1);
	assign mid_sum  = {1'b0, index_q} + {1'b0, MID_OFS};
	assign mid_addr = (mid_sum >= DEPTH_EXT) ? addr_t'(mid_sum - DEPTH_EXT)
	                                         : mid_sum[mtp_pkg::ADDR_W-1:0];

	// Seeding recurrence step
	assign fill_mix  = prev_q ^ (prev_q >> 30);
	assign fill_prod = mtp_pkg::INIT_MULT * fill_mix;
	assign fill_word = fill_prod + {{(32-mtp_pkg::ADDR_W){1'b0}}, fill_idx_q};

	// Twist of one word
	assign y_word  = {cur_q[31], rd_nxt_s1[30:0]};
	assign twist_w = rd_mid_s1 ^ {1'b0, y_word[31:1]}
	               ^ (y_word[0] ? mtp_pkg::TWIST_MATRIX : 32'h0);

	// RAM write port: refill has priority
	always_comb begin
		mem_we    = fill_q || valid_s1;
		mem_waddr = fill_q ? fill_idx_q : widx_s1;
		if (fill_q) begin
			mem_wdata = (fill_idx_q == '0) ? seed_q : fill_word;
		end else begin
			mem_wdata = twist_w;
		end
	end

	// State RAM: one write, two registered reads
	always_ff @(posedge clk) begin
		if (mem_we) begin
			state_mem[mem_waddr] <= mem_wdata;
		end
		if (take) begin
			rd_nxt_s1 <= state_mem[nxt_addr];
			rd_mid_s1 <= state_mem[mid_addr];
		end
	end

	// Seed register and refill sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q     <= mtp_pkg::DEFAULT_SEED;
			fill_q     <= 1'b1;
			fill_idx_q <= '0;
		end else if (cfg_we) begin
			seed_q     <= cfg_wdata;
			fill_q     <= 1'b1;
			fill_idx_q <= '0;
		end else if (fill_q) begin
			if (fill_idx_q == LAST_ADDR) begin
				fill_q     <= 1'b0;
				fill_idx_q <= '0;
			end else begin
				fill_idx_q <= fill_idx_q + addr_t'(1);
			end
		end
	end

	// Twist index and stage 1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			index_q  <= '0;
			valid_s1 <= 1'b0;
			widx_s1  <= '0;
		end else begin
			if (cfg_we) begin
				index_q <= '0;
			end else if (take) begin
				index_q <= nxt_addr;
			end
			valid_s1 <= take;
			if (take) begin
				widx_s1 <= index_q;
			end
		end
	end

	// Previous seeding word and cached current state word
	always_ff @(posedge clk) begin
		if (fill_q) begin
			if (fill_idx_q == '0) begin
				prev_q <= seed_q;
				cur_q  <= seed_q;
			end else begin
				prev_q <= fill_word;
			end
		end else if (valid_s1) begin
			cur_q <= rd_nxt_s1;
		end
	end

	// Output queue payload
	always_ff @(posedge clk) begin
		if (valid_s1) begin
			outq_q[wr_ptr_q] <= mtp_pkg::temper(twist_w);
		end
	end

	// Output queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (valid_s1) begin
				wr_ptr_q <= (wr_ptr_q == Q_LAST) ? '0 : wr_ptr_q + qptr_t'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == Q_LAST) ? '0 : rd_ptr_q + qptr_t'(1);
			end
			unique case ({valid_s1, pop})
				2'b10:   cnt_q <= cnt_q + qcnt_t'(1);
				2'b01:   cnt_q <= cnt_q - qcnt_t'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	assign out_valid = (cnt_q != '0);
	assign word32    = outq_q[rd_ptr_q];
	assign word31    = word32[31:1];

	// Checks
	`ASSERT_ALWAYS(a_no_twist_in_fill, clk, arst_n, !(fill_q && valid_s1),
		"twist write overlaps state refill")
	`ASSERT_IMPLIES(a_no_ram_clash, clk, arst_n, take && valid_s1,
		(widx_s1 != nxt_addr) && (widx_s1 != mid_addr),
		"RAM write address collides with a read address")
	`ASSERT_ALWAYS(a_outq_room, clk, arst_n, occupancy <= Q_FULL,
		"output queue overflow")
	`ASSERT_ALWAYS(a_index_range, clk, arst_n, index_q <= LAST_ADDR,
		"twist index beyond state depth")

endmodule
